// File: hdl/bad_pkg.sv
// Package with the shared types and codes of the bounded array deque.
`timescale 1ns / 1ps

package bad_pkg;

    // Operation carried by one input transaction.
    typedef enum logic [1:0] {
        ACT_PUSH_HEAD = 2'd0,
        ACT_PUSH_TAIL = 2'd1,
        ACT_POP_HEAD  = 2'd2,
        ACT_POP_TAIL  = 2'd3
    } t_action;

    // Outcome reported with every result transaction.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL_HEAD = 2'd1,
        ST_FULL_TAIL = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    localparam int WORD_W = 32;
    localparam int CAP_W  = 5;

    // Value returned on inserts and on failed removals.
    localparam logic signed [WORD_W-1:0] NO_WORD = '1;

    typedef struct packed {
        t_action                   action;
        logic signed [WORD_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0]  removed_value;
        t_status                   status;
    } t_out_item;

endpackage

// File: hdl/bounded_array_deque.sv
// Top level of the bounded array deque: pointer control, slot RAM and output stage.
`timescale 1ns / 1ps

// The block keeps a double-ended queue of signed 32-bit words in a plain,
// non-circular array of DEPTH slots, of which the first capacity_in_use slots
// (written through i_cfg_we / i_cfg_data, reset value 16, zero is taken as one
// and values above DEPTH as DEPTH) may hold data. Every input transaction
// inserts at the head, inserts at the tail, removes the head or removes the
// tail, and produces exactly one result transaction carrying the removed word
// (all ones on inserts and failed removals) and a status. The first insert
// into an empty deque always lands in slot 0; the head can only grow down to
// slot 0 and the tail only up to the last usable slot, so a head insert is
// refused while the head is at slot 0 and a tail insert is refused at the last
// usable slot, even if slots at the other end are free. Once the deque drains,
// both pointers go back to slot 0. The block takes one transaction per clock
// cycle unless the consumer stalls it. The pointers and the single slot RAM
// access are settled in the cycle of acceptance, the RAM's registered read
// port delivers the word in the next cycle, and the output register takes it
// as soon as it is free or being emptied. The output
// register and the stage in front of it let the input keep flowing while the
// consumer stalls, until both are occupied. Slots that were never written are
// never read through this interface, so the RAM needs no clearing after reset.
// Capacity may only be changed while no transaction is in flight.

module bounded_array_deque
    import bad_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,

    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,

    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data
);

    // Pointer and count widths follow from the depth; the compare width also from CAP_W.
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int UW = ((CW > CAP_W) ? CW : CAP_W) + 1;

    // Architectural state of the deque.
    logic [PW-1:0]    r_head, n_head;
    logic [PW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_count, n_count;
    logic [CAP_W-1:0] r_cap;

    // Stage one waits for the RAM read data; the output register follows it.
    logic             r_s1_valid, n_s1_valid;
    t_status          r_s1_status, n_s1_status;
    logic             r_s1_pop, n_s1_pop;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             accept;
    logic             s1_adv;
    logic [UW-1:0]    usable;
    logic [UW-1:0]    tail_next_ext;

    logic             ram_we;
    logic [PW-1:0]    ram_waddr;
    logic             ram_re;
    logic [PW-1:0]    ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // Stage one moves forward whenever the output register is free or being
    // emptied; a new transaction enters whenever stage one can make room.
    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    // Usable slot count with the configured capacity clamped to 1..DEPTH.
    always_comb begin
        if (r_cap == '0) begin
            usable = UW'(1);
        end else if (UW'(r_cap) > UW'(DEPTH)) begin
            usable = UW'(DEPTH);
        end else begin
            usable = UW'(r_cap);
        end
    end

    assign tail_next_ext = UW'(r_tail) + UW'(1);

    // Pointer update and slot access for the transaction being accepted.
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_s1_status = ST_OK;
        n_s1_pop    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_head;
        ram_re      = 1'b0;
        ram_raddr   = r_head;
        case (i_in_data.action)
            ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
                if (r_count == '0) begin
                    // An empty deque always restarts in slot 0.
                    n_head    = '0;
                    n_tail    = '0;
                    n_count   = CW'(1);
                    ram_we    = accept;
                    ram_waddr = '0;
                end else if (i_in_data.action == ACT_PUSH_HEAD) begin
                    if (r_head == '0) begin
                        n_s1_status = ST_FULL_HEAD;
                    end else begin
                        n_head    = r_head - PW'(1);
                        n_count   = r_count + CW'(1);
                        ram_we    = accept;
                        ram_waddr = r_head - PW'(1);
                    end
                end else begin
                    if (tail_next_ext >= usable) begin
                        n_s1_status = ST_FULL_TAIL;
                    end else begin
                        n_tail    = r_tail + PW'(1);
                        n_count   = r_count + CW'(1);
                        ram_we    = accept;
                        ram_waddr = r_tail + PW'(1);
                    end
                end
            end
            ACT_POP_HEAD, ACT_POP_TAIL: begin
                if (r_count == '0) begin
                    n_s1_status = ST_EMPTY;
                end else begin
                    n_s1_pop  = 1'b1;
                    ram_re    = accept;
                    ram_raddr = (i_in_data.action == ACT_POP_HEAD) ? r_head : r_tail;
                    n_count   = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        // Last word leaves: both pointers return to slot 0.
                        n_head = '0;
                        n_tail = '0;
                    end else if (i_in_data.action == ACT_POP_HEAD) begin
                        n_head = r_head + PW'(1);
                    end else begin
                        n_tail = r_tail - PW'(1);
                    end
                end
            end
            default: begin
                n_s1_status = ST_OK;
            end
        endcase
    end

    // Stage and output register handshaking.
    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (o_in_ready) begin
            n_s1_valid = accept;
        end
        if (s1_adv) begin
            n_out_valid         = r_s1_valid;
            n_out.status        = r_s1_status;
            n_out.removed_value = r_s1_pop ? ram_rdata : NO_WORD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_cap       <= CAP_W'(16);
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= n_s1_status;
            r_s1_pop    <= n_s1_pop;
        end
        r_out <= n_out;
    end

    bad_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_data.value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The count never exceeds the number of physical slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        UW'(r_count) <= UW'(DEPTH))
        else $error("deque count exceeds depth");

    // An empty deque parks both pointers at slot 0.
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == '0 && r_tail == '0))
        else $error("empty deque with pointers away from slot 0");

    // Occupied slots are exactly those from head to tail.
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> ((CW'(r_tail) - CW'(r_head) + CW'(1)) == r_count))
        else $error("pointer span disagrees with count");

    // A removal from a non-empty deque reaches stage one as a successful read.
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_count != '0 && (i_in_data.action == ACT_POP_HEAD ||
            i_in_data.action == ACT_POP_TAIL))
        |=> (r_s1_valid && r_s1_pop && r_s1_status == ST_OK))
        else $error("removal from a non-empty deque not reported as ok");

endmodule

// File: hdl/bad_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module bad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sim/tb_bounded_array_deque.sv
// Self-checking testbench for the bounded array deque.
`timescale 1ns / 1ps

// The testbench sends deque operations as input transactions and keeps its
// own copy of the deque: slot contents, head and tail pointers, fill count and
// the capacity register. Each accepted operation is run through that copy
// right away. The outcome it gives is queued, and every result transaction
// leaving the block is compared with the oldest queued outcome.
//
// The run is a sequence of named tests, one initial block calling them in
// turn:
//   - directed corner cases: removals from an empty deque, inserts at both
//     ends, a refusal at slot 0, extreme words, and the pointers going
//     back to slot 0 once the deque drains;
//   - capacity extremes: one slot with refusals at both ends, zero (taken
//     as one), and values above the array depth (taken as the full depth);
//   - capacity lowered below the occupied slots while data is stored;
//   - back pressure: the receiver holds off for a long stretch while the
//     sender keeps offering, so the block fills up and stalls its input;
//   - random traffic in four idling phases (none, sender idle, receiver
//     stalling, both). The capacity is changed between chunks of a phase.
//
// Configuration writes happen only when no result is outstanding. Every
// operation yields exactly one result, so an empty queue of outcomes means
// the block is idle.

module tb_bounded_array_deque;

    import bad_pkg::*;

    localparam int DEPTH       = 16;
    localparam int HOLD_CYCLES = 300;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_item         i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out_item        o_out_data;

    bounded_array_deque #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // Testbench copy of the deque state.
    logic signed [WORD_W-1:0] dq_words [DEPTH];
    int unsigned              dq_head;
    int unsigned              dq_tail;
    int unsigned              dq_fill;
    logic [CAP_W-1:0]         dq_capacity;

    // Outcomes still waiting for their result transaction.
    t_out_item pending_results [$];

    int mismatch_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Computes the outcome of one operation and advances the deque copy.
    function automatic t_out_item deque_outcome(t_in_item op);
        t_out_item   res;
        int unsigned usable;
        res.removed_value = NO_WORD;
        res.status        = ST_OK;
        usable = dq_capacity;
        if (usable < 1) usable = 1;
        if (usable > DEPTH) usable = DEPTH;
        case (op.action)
            ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
                if (dq_fill == 0) begin
                    // The first word always lands in slot 0, whichever end.
                    dq_head     = 0;
                    dq_tail     = 0;
                    dq_words[0] = op.value;
                    dq_fill     = 1;
                end else if (op.action == ACT_PUSH_HEAD) begin
                    if (dq_head == 0) begin
                        res.status = ST_FULL_HEAD;
                    end else begin
                        dq_head--;
                        dq_words[dq_head] = op.value;
                        dq_fill++;
                    end
                end else begin
                    if (dq_tail + 1 >= usable) begin
                        res.status = ST_FULL_TAIL;
                    end else begin
                        dq_tail++;
                        dq_words[dq_tail] = op.value;
                        dq_fill++;
                    end
                end
            end
            default: begin
                if (dq_fill == 0) begin
                    res.status = ST_EMPTY;
                end else if (op.action == ACT_POP_HEAD) begin
                    res.removed_value = dq_words[dq_head];
                    dq_fill--;
                    if (dq_fill != 0) dq_head++;
                end else begin
                    res.removed_value = dq_words[dq_tail];
                    dq_fill--;
                    if (dq_fill != 0 && dq_tail != 0) dq_tail--;
                end
                if (dq_fill == 0) begin
                    dq_head = 0;
                    dq_tail = 0;
                end
            end
        endcase
        return res;
    endfunction

    // Offers one operation and returns at the edge where it is accepted.
    // Valid is left high; the next call or release_input decides what follows
    // in the same time step, so valid is never lowered and raised at once.
    task automatic offer_operation(input t_action act, input logic signed [WORD_W-1:0] word);
        t_in_item op;
        op.action = act;
        op.value  = word;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= op;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(deque_outcome(op));
    endtask

    task automatic release_input();
        i_in_valid <= 1'b0;
    endtask

    // Writes the capacity register once every outstanding result is back.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        release_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_data <= cap;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        dq_capacity  = cap;
    endtask

    // Random word with a bias toward the extremes.
    function automatic logic signed [WORD_W-1:0] random_word();
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Operation mix for one burst. Fill and head modes give well-formed
    // sequences that move both pointers away from slot 0; the uniform mode
    // adds noise such as removals from an empty deque.
    function automatic t_action random_action(input int mode);
        int pick;
        pick = $urandom_range(0, 99);
        case (mode)
            0: begin
                if (pick < 65) return ACT_PUSH_TAIL;
                if (pick < 85) return ACT_POP_HEAD;
                if (pick < 93) return ACT_PUSH_HEAD;
                return ACT_POP_TAIL;
            end
            1: begin
                if (pick < 45) return ACT_POP_HEAD;
                if (pick < 90) return ACT_POP_TAIL;
                return ACT_PUSH_TAIL;
            end
            2: begin
                if (pick < 35) return ACT_POP_HEAD;
                if (pick < 75) return ACT_PUSH_HEAD;
                if (pick < 90) return ACT_PUSH_TAIL;
                return ACT_POP_TAIL;
            end
            default: return t_action'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic test_directed_edges();
        offer_operation(ACT_POP_HEAD,  32'sd5);
        offer_operation(ACT_POP_TAIL,  32'sd5);
        offer_operation(ACT_PUSH_HEAD, 32'sh7FFF_FFFF);
        offer_operation(ACT_PUSH_HEAD, 32'sh1234_5678);
        offer_operation(ACT_PUSH_TAIL, 32'sh8000_0000);
        offer_operation(ACT_PUSH_TAIL, 32'sd0);
        offer_operation(ACT_PUSH_TAIL, -32'sd1);
        offer_operation(ACT_POP_HEAD,  32'sd0);
        offer_operation(ACT_PUSH_HEAD, 32'sh5555_5555);
        offer_operation(ACT_POP_TAIL,  32'sd0);
        offer_operation(ACT_POP_TAIL,  32'sd0);
        offer_operation(ACT_POP_TAIL,  32'sd0);
        offer_operation(ACT_POP_TAIL,  32'sd0);
        offer_operation(ACT_POP_HEAD,  32'sd0);
        // A tail insert into an empty deque must also place the head.
        offer_operation(ACT_PUSH_TAIL, 32'shAAAA_AAAA);
        offer_operation(ACT_POP_HEAD,  32'sd0);
        offer_operation(ACT_PUSH_TAIL, 32'sh0F0F_0F0F);
        offer_operation(ACT_POP_TAIL,  32'sd0);
    endtask

    task automatic test_capacity_bounds();
        // One slot, then zero which must behave as one slot.
        set_capacity(5'd1);
        offer_operation(ACT_PUSH_TAIL, 32'sh0000_0001);
        offer_operation(ACT_PUSH_TAIL, 32'sh0000_0002);
        offer_operation(ACT_PUSH_HEAD, 32'sh0000_0003);
        offer_operation(ACT_POP_TAIL,  32'sd0);
        set_capacity(5'd0);
        offer_operation(ACT_PUSH_HEAD, 32'sh0000_0004);
        offer_operation(ACT_PUSH_TAIL, 32'sh0000_0005);
        offer_operation(ACT_POP_HEAD,  32'sd0);
        // Above the array depth the whole array is usable and no more.
        set_capacity(5'd31);
        for (int i = 0; i <= DEPTH; i++) begin
            offer_operation(ACT_PUSH_TAIL, random_word());
        end
    endtask

    // Lowers the capacity while the whole array is occupied: the stored
    // words stay, and tail inserts stay refused until the tail drops below
    // the new last usable slot.
    task automatic test_capacity_lowered();
        set_capacity(5'd3);
        offer_operation(ACT_PUSH_TAIL, random_word());
        for (int i = 0; i < DEPTH - 3; i++) begin
            offer_operation(ACT_POP_TAIL, random_word());
        end
        offer_operation(ACT_PUSH_TAIL, random_word());
        offer_operation(ACT_POP_TAIL,  random_word());
        offer_operation(ACT_PUSH_TAIL, random_word());
        offer_operation(ACT_POP_HEAD,  random_word());
        offer_operation(ACT_PUSH_HEAD, random_word());
    endtask

    // The receiver holds off for a long stretch on its own while the sender
    // keeps offering without gaps, so the block fills up and stalls its input.
    task automatic test_backpressure_fill();
        set_capacity(5'd16);
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = HOLD_CYCLES;
        for (int i = 0; i < 40; i++) begin
            offer_operation(random_action(i < 24 ? 0 : 1), random_word());
        end
    endtask

    // One idling phase of random traffic, split into chunks with a fresh
    // capacity before each chunk.
    task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct);
        int               mode;
        logic [CAP_W-1:0] cap;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        mode           = 3;
        for (int i = 0; i < items; i++) begin
            if (i % 120 == 0) begin
                case ($urandom_range(0, 7))
                    0, 1:    cap = 5'd16;
                    2:       cap = 5'd1;
                    3:       cap = 5'($urandom_range(17, 31));
                    4:       cap = 5'd0;
                    default: cap = 5'($urandom_range(2, 15));
                endcase
                set_capacity(cap);
            end
            if (i % 24 == 0) mode = $urandom_range(0, 3);
            offer_operation(random_action(mode), random_word());
        end
    endtask

    // Receiver: random stalls, plus a long hold-off when a test asks for it.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                int n;
                n               = hold_off_cycles;
                hold_off_cycles = 0;
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compares every result transaction with the oldest queued outcome.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result removed_value %h status %0d",
                         $time, o_out_data.removed_value, o_out_data.status);
                mismatch_count++;
            end else begin
                t_out_item want;
                want = pending_results.pop_front();
                if (o_out_data.removed_value !== want.removed_value) begin
                    $display("%0t: removed_value mismatch: expected %h actual %h",
                             $time, want.removed_value, o_out_data.removed_value);
                    mismatch_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, o_out_data.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_in_data       = '0;
        mismatch_count  = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        dq_head         = 0;
        dq_tail         = 0;
        dq_fill         = 0;
        dq_capacity     = 5'd16;
        foreach (dq_words[i]) dq_words[i] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_capacity_bounds();
        test_capacity_lowered();
        test_backpressure_fill();
        test_random_traffic(360, 0, 0);
        test_random_traffic(360, 49, 0);
        test_random_traffic(360, 0, 49);
        test_random_traffic(360, 20, 20);

        release_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
